// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define AST_CLK(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// Checked at every edge, reset included.
`define AST_ALL(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");

`endif

// File: hw/rtl/rgbg_pkg.sv
// Shared constants, stage payload types and the square root step for the gray converter.
package rgbg_pkg;

    localparam logic [15:0] W_RED   = 16'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [15:0] W_BLUE  = 16'd7471;

    // floor(x / 6) = (x * 683) >> 12 for x < 1536
    localparam logic [9:0] DIV6_MUL   = 10'd683;
    localparam int         DIV6_SHIFT = 12;

    localparam int SQRT_STAGES = 4;
    localparam int SQRT_STEPS  = 2;
    localparam int PIPE_DEPTH  = 8;

    typedef struct packed {
        logic        fast;
        logic [15:0] rr;
        logic [15:0] gg;
        logic [15:0] bb;
        logic [10:0] sum;
    } sq_t;

    typedef struct packed {
        logic        fast;
        logic [31:0] pr;
        logic [31:0] pg;
        logic [31:0] pb;
        logic [20:0] fprod;
    } wp_t;

    typedef struct packed {
        logic        fast;
        logic [7:0]  fgray;
        logic [15:0] v;
        logic [8:0]  rem;
        logic [7:0]  root;
    } sr_t;

    // one digit of the restoring square root: two radicand bits in, one root bit out
    function automatic sr_t sqrt_step(input sr_t x);
        logic [10:0] acc;
        logic [10:0] trial;
        sr_t         y;
        acc   = {x.rem, x.v[15:14]};
        trial = {1'b0, x.root, 2'b01};
        y     = x;
        y.v   = {x.v[13:0], 2'b00};
        if (acc >= trial) begin
            y.rem  = 9'(acc - trial);
            y.root = {x.root[6:0], 1'b1};
        end else begin
            y.rem  = acc[8:0];
            y.root = {x.root[6:0], 1'b0};
        end
        return y;
    endfunction

endpackage

// File: hw/rtl/rgb_to_gray_two_mode.sv
// Top level of the RGB to gray converter with fast and accurate modes.
// Takes one RGB pixel per clock and returns one gray byte per pixel, in order, after
// the pixel passes through one stage of squares, one of weight multipliers,
// one adder stage, four square-root stages of two root bits each, and the output
// register. Sustained rate is one pixel per clock whenever m_tready stays high; a
// stall holds every full stage and empty stages keep filling. cfg_wr_data bit 0 is
// fast_mode (1: floor((2r+3g+b)/6), 0: truncated luma root of weighted squares); each
// pixel uses the mode in force when it is taken, and the mode resets to accurate.
module rgb_to_gray_two_mode (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // gray [7:0]
);
    import rgbg_pkg::*;

    logic       fast_mode_reg;
    logic       sq_valid;
    logic       sq_ready;
    sq_t        sq_data;
    logic       wt_valid;
    logic       wt_ready;
    sr_t        wt_data;
    logic       rt_valid;
    logic       rt_ready;
    sr_t        rt_data;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic [7:0] m_tdata_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            fast_mode_reg <= cfg_wr_data;
        end
    end

    rgbg_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .fast      (fast_mode_reg),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_data  (sq_data)
    );

    rgbg_weight u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_data   (sq_data),
        .out_valid (wt_valid),
        .out_ready (wt_ready),
        .out_data  (wt_data)
    );

    rgbg_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (wt_valid),
        .in_ready  (wt_ready),
        .in_data   (wt_data),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .out_data  (rt_data)
    );

    assign rt_ready     = !m_tvalid_reg || m_tready;
    assign m_tdata_next = rt_data.fast ? rt_data.fgray : rt_data.root;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rt_ready) begin
            m_tvalid_reg <= rt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rt_ready && rt_valid) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

// File: hw/rtl/rgbg_square.sv
// First stage: squares of the color components and the fast-mode weighted sum.
module rgbg_square (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic             fast,
    output logic             out_valid,
    input  logic             out_ready,
    output rgbg_pkg::sq_t    out_data
);
    import rgbg_pkg::*;

    logic valid_reg;
    sq_t  data_reg;
    sq_t  data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.fast = fast;
        data_next.rr   = 16'(red) * 16'(red);
        data_next.gg   = 16'(green) * 16'(green);
        data_next.bb   = 16'(blue) * 16'(blue);
        data_next.sum  = 11'({red, 1'b0}) + 11'({green, 1'b0}) + 11'(green) + 11'(blue);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: hw/rtl/rgbg_weight.sv
// Two stages: luma-weighted squares and the divide by six, then the weighted sum.
module rgbg_weight (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rgbg_pkg::sq_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rgbg_pkg::sr_t    out_data
);
    import rgbg_pkg::*;

    logic        prod_valid_reg;
    wp_t         prod_reg;
    wp_t         prod_next;
    logic        prod_ready;
    logic        sum_valid_reg;
    sr_t         sum_reg;
    sr_t         sum_next;
    logic [31:0] total;

    assign prod_ready = !sum_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;
    assign out_valid  = sum_valid_reg;
    assign out_data   = sum_reg;

    always_comb begin
        prod_next.fast  = in_data.fast;
        prod_next.pr    = 32'(in_data.rr) * 32'(W_RED);
        prod_next.pg    = 32'(in_data.gg) * 32'(W_GREEN);
        prod_next.pb    = 32'(in_data.bb) * 32'(W_BLUE);
        prod_next.fprod = 21'(in_data.sum) * 21'(DIV6_MUL);
    end

    // the weights sum to 2^16, so the total never exceeds 32 bits
    always_comb begin
        total          = prod_reg.pr + prod_reg.pg + prod_reg.pb;
        sum_next.fast  = prod_reg.fast;
        sum_next.fgray = prod_reg.fprod[DIV6_SHIFT +: 8];
        sum_next.v     = total[31:16];
        sum_next.rem   = '0;
        sum_next.root  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                sum_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
        if (prod_ready && prod_valid_reg) begin
            sum_reg <= sum_next;
        end
    end

endmodule

// File: hw/rtl/rgbg_sqrt.sv
// Pipelined restoring square root of the upper half of the weighted sum.
module rgbg_sqrt (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rgbg_pkg::sr_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rgbg_pkg::sr_t    out_data
);
    import rgbg_pkg::*;

    logic [SQRT_STAGES-1:0] valid_reg;
    logic [SQRT_STAGES-1:0] stage_ready;
    logic [SQRT_STAGES-1:0] stage_vin;
    sr_t                    data_reg  [SQRT_STAGES];
    sr_t                    data_next [SQRT_STAGES];

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_data  = data_reg[SQRT_STAGES-1];

    always_comb begin
        stage_ready[SQRT_STAGES-1] = !valid_reg[SQRT_STAGES-1] || out_ready;
        for (int k = SQRT_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (k == 0) begin
                stage_vin[k] = in_valid;
                data_next[k] = in_data;
            end else begin
                stage_vin[k] = valid_reg[k-1];
                data_next[k] = data_reg[k-1];
            end
            for (int j = 0; j < SQRT_STEPS; j++) begin
                data_next[k] = sqrt_step(data_next[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= stage_vin[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < SQRT_STAGES; k++) begin
            if (stage_ready[k] && stage_vin[k]) begin
                data_reg[k] <= data_next[k];
            end
        end
    end

endmodule

// File: hw/rtl/rgbg_checker.sv
// Port-level checker for the gray converter and its bind to the top level.
`include "assert_macros.svh"

module rgbg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    import rgbg_pkg::*;

    // requests in flight between the two sides
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc) begin
            cnt_next = cnt_reg + 4'd1;
        end else if (out_acc && !in_acc) begin
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `AST_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `AST_ALL(a_reset_empty, !aresetn |=> !m_tvalid)
    `AST_CLK(a_no_invented, m_tvalid |-> cnt_reg != 4'd0)
    `AST_CLK(a_depth_bound, cnt_reg <= 4'(PIPE_DEPTH))
    `AST_CLK(a_ready_when_empty, cnt_reg == 4'd0 |-> s_tready)

endmodule

bind rgb_to_gray_two_mode rgbg_checker u_rgbg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
